@@ rtl/core/ggvc_pkg.sv @@
// Shared widths, constants, stage indices and types for the go-to-goal velocity command block.
package ggvc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  localparam int POS_W      = 32;
  localparam int DIFF_W     = POS_W + 1;
  localparam int MAG_W      = POS_W;
  localparam int TOL_W      = 31;
  localparam int SQ_W       = 2 * TOL_W;
  localparam int HD_W       = 16;
  localparam int CW         = 36;
  localparam int ZW         = 34;
  localparam int BEAR_W     = 18;
  localparam int ERRRAW_W   = 19;
  localparam int ERR_W      = 17;
  localparam int GAIN_W     = 16;
  localparam int HTOL_W     = 15;
  localparam int PROD_W     = 2 * ERR_W;
  localparam int RATE_W     = 32;
  localparam int SPEED_W    = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam int ANG_SHIFT  = 17;
  localparam int RATE_SHIFT = 5;

  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  localparam logic signed [ZW-1:0] ROT_Z = ZW'({ATAN_Q30[0], 1'b0});
  localparam logic signed [ZW:0] ANG_ROUND = (ZW + 1)'(1 << (ANG_SHIFT - 1));
  localparam logic signed [PROD_W:0] RATE_ROUND = (PROD_W + 1)'(1 << (RATE_SHIFT - 1));
  localparam logic signed [ERRRAW_W-1:0] ANG_PI     = ERRRAW_W'(25736);
  localparam logic signed [ERRRAW_W-1:0] ANG_TWO_PI = ERRRAW_W'(51472);

  localparam logic [CFG_IDX_W-1:0] REG_DIST_TOL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_TOL  = CFG_IDX_W'(3);

  localparam logic [TOL_W-1:0]   RST_DIST_TOL  = TOL_W'(6554);
  localparam logic [SPEED_W-1:0] RST_MAX_SPEED = SPEED_W'(32768);
  localparam logic [GAIN_W-1:0]  RST_TURN_GAIN = GAIN_W'(2560);
  localparam logic [HTOL_W-1:0]  RST_HEAD_TOL  = HTOL_W'(82);

  localparam int ST_DIFF    = 0;
  localparam int ST_PREROT  = 1;
  localparam int ST_SQUARE  = 2;
  localparam int ST_NEAR    = 3;
  localparam int ST_CORDIC  = 4;
  localparam int ST_BEAR    = ST_CORDIC + CORDIC_N;
  localparam int ST_ERR     = ST_BEAR + 1;
  localparam int ST_WRAP    = ST_ERR + 1;
  localparam int ST_MUL     = ST_WRAP + 1;
  localparam int ST_OUT     = ST_MUL + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  typedef struct packed {
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [ZW-1:0]   z;
    logic                   zero;
    logic                   near;
    logic signed [HD_W-1:0] hd;
  } cordic_t;

endpackage

@@ rtl/core/ggvc_in_if.sv @@
// Pose and goal input channel.
interface ggvc_in_if;
  import ggvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] robot_x;
  logic signed [POS_W-1:0] robot_y;
  logic signed [HD_W-1:0]  robot_heading;
  logic signed [POS_W-1:0] goal_x;
  logic signed [POS_W-1:0] goal_y;

  modport source (
    output valid, robot_x, robot_y, robot_heading, goal_x, goal_y,
    input  ready
  );

  modport sink (
    input  valid, robot_x, robot_y, robot_heading, goal_x, goal_y,
    output ready
  );
endinterface

@@ rtl/core/ggvc_out_if.sv @@
// Velocity command output channel.
interface ggvc_out_if;
  import ggvc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [SPEED_W-1:0]       linear_speed;
  logic signed [RATE_W-1:0] turn_rate;
  logic                     at_goal;

  modport source (
    output valid, linear_speed, turn_rate, at_goal,
    input  ready
  );

  modport sink (
    input  valid, linear_speed, turn_rate, at_goal,
    output ready
  );
endinterface

@@ rtl/core/go_to_goal_velocity_command_unit.sv @@
// Top level of the go-to-goal velocity command block: goal test, CORDIC bearing, turn law.
//
//   channel   direction  transfer when          contents
//   in_chan   in         valid && ready         robot pose and goal point
//   out_chan  out        valid && ready         linear_speed, turn_rate, at_goal
//   cfg_*     in         cfg_wr_en              register index and write data
//
// One item enters per cycle while the output is not stalled; the pipeline has NUM_STAGES
// register stages, one per CORDIC micro-rotation plus nine stages of setup and math.
// Each stage holds its item until the next one is free, so a stalled output fills the
// pipeline bubble by bubble before in_chan.ready drops.
// Reset clears all stage valid bits and loads the register reset values.
module go_to_goal_velocity_command_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  ggvc_in_if.sink                        in_chan,
  ggvc_out_if.source                     out_chan,
  input  logic                           cfg_wr_en,
  input  logic [ggvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ggvc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ggvc_pkg::*;

  logic [TOL_W-1:0]   dist_tol_r;
  logic [SPEED_W-1:0] max_speed_r;
  logic [GAIN_W-1:0]  turn_gain_r;
  logic [HTOL_W-1:0]  head_tol_r;
  logic [SQ_W-1:0]    tolsq_r;

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  logic [NUM_STAGES-1:0] upstream_v;
  logic [NUM_STAGES-1:0] stage_en;

  logic signed [DIFF_W-1:0] dx_nxt;
  logic signed [DIFF_W-1:0] dy_nxt;
  logic signed [DIFF_W-1:0] dx_r;
  logic signed [DIFF_W-1:0] dy_r;
  logic signed [HD_W-1:0]   hd_diff_r;

  logic [MAG_W-1:0]     ax_nxt;
  logic [MAG_W-1:0]     ay_nxt;
  logic [MAG_W-1:0]     ax_r;
  logic [MAG_W-1:0]     ay_r;
  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;
  cordic_t              c1_nxt;
  cordic_t              c1_r;

  logic [SQ_W-1:0] sqx_r;
  logic [SQ_W-1:0] sqy_r;
  logic            ltx_r;
  logic            lty_r;
  cordic_t         c2_r;

  logic [SQ_W:0] sq_sum;
  cordic_t       c3_nxt;
  cordic_t       c3_r;
  cordic_t       cout;

  logic signed [ZW:0]       zsum;
  logic signed [BEAR_W-1:0] bear_nxt;
  logic signed [BEAR_W-1:0] bear_r;
  logic signed [HD_W-1:0]   hd_bear_r;
  logic                     near_bear_r;

  logic signed [ERRRAW_W-1:0] err_raw_r;
  logic                       near_err_r;

  logic signed [ERR_W-1:0] err_nxt;
  logic signed [ERR_W-1:0] err_r;
  logic                    near_wrap_r;

  logic [ERR_W-1:0]         abs_err;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic                     lin_ok_r;
  logic                     near_mul_r;

  logic signed [PROD_W:0]   rsum;
  logic signed [RATE_W-1:0] rate;
  logic [SPEED_W-1:0]       linear_speed_r;
  logic signed [RATE_W-1:0] turn_rate_r;
  logic                     at_goal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_tol_r  <= RST_DIST_TOL;
      max_speed_r <= RST_MAX_SPEED;
      turn_gain_r <= RST_TURN_GAIN;
      head_tol_r  <= RST_HEAD_TOL;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DIST_TOL:  dist_tol_r  <= cfg_data[TOL_W-1:0];
        REG_MAX_SPEED: max_speed_r <= cfg_data[SPEED_W-1:0];
        REG_TURN_GAIN: turn_gain_r <= cfg_data[GAIN_W-1:0];
        REG_HEAD_TOL:  head_tol_r  <= cfg_data[HTOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tolsq_r <= SQ_W'(dist_tol_r) * SQ_W'(dist_tol_r);
  end

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
    assign stage_en[k] = out_chan.ready | ~(&v_r[NUM_STAGES-1:k]);
  end

  assign upstream_v = {v_r[NUM_STAGES-2:0], in_chan.valid};

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      v_nxt[k] = stage_en[k] ? upstream_v[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_chan.ready = stage_en[ST_DIFF];

  assign dx_nxt = DIFF_W'(in_chan.goal_x) - DIFF_W'(in_chan.robot_x);
  assign dy_nxt = DIFF_W'(in_chan.goal_y) - DIFF_W'(in_chan.robot_y);

  assign ax_nxt = dx_r[DIFF_W-1] ? MAG_W'(-dx_r) : MAG_W'(dx_r);
  assign ay_nxt = dy_r[DIFF_W-1] ? MAG_W'(-dy_r) : MAG_W'(dy_r);
  assign xe     = CW'(dx_r);
  assign ye     = CW'(dy_r);

  always_comb begin
    c1_nxt      = '0;
    c1_nxt.hd   = hd_diff_r;
    c1_nxt.zero = (dx_r == '0) && (dy_r == '0);
    c1_nxt.near = 1'b0;
    if (xe < 0) begin
      if (ye >= 0) begin
        c1_nxt.x = ye;
        c1_nxt.y = -xe;
        c1_nxt.z = ROT_Z;
      end else begin
        c1_nxt.x = -ye;
        c1_nxt.y = xe;
        c1_nxt.z = -ROT_Z;
      end
    end else begin
      c1_nxt.x = xe;
      c1_nxt.y = ye;
      c1_nxt.z = '0;
    end
  end

  assign sq_sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_comb begin
    c3_nxt      = c2_r;
    c3_nxt.near = ltx_r && lty_r && (sq_sum < {1'b0, tolsq_r});
  end

  assign zsum     = (ZW + 1)'(cout.z) + ANG_ROUND;
  assign bear_nxt = cout.zero ? '0 : BEAR_W'(zsum >>> ANG_SHIFT);

  always_comb begin
    if (err_raw_r > ANG_PI) begin
      err_nxt = ERR_W'(err_raw_r - ANG_TWO_PI);
    end else if (err_raw_r <= -ANG_PI) begin
      err_nxt = ERR_W'(err_raw_r + ANG_TWO_PI);
    end else begin
      err_nxt = ERR_W'(err_raw_r);
    end
  end

  assign abs_err  = (err_r < 0) ? ERR_W'(-err_r) : ERR_W'(err_r);
  assign prod_nxt = PROD_W'(err_r) * PROD_W'($signed({1'b0, turn_gain_r}));

  assign rsum = (PROD_W + 1)'(prod_r) + RATE_ROUND;
  assign rate = RATE_W'(rsum >>> RATE_SHIFT);

  always_ff @(posedge clk) begin
    if (stage_en[ST_DIFF]) begin
      dx_r      <= dx_nxt;
      dy_r      <= dy_nxt;
      hd_diff_r <= in_chan.robot_heading;
    end
    if (stage_en[ST_PREROT]) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      c1_r <= c1_nxt;
    end
    if (stage_en[ST_SQUARE]) begin
      sqx_r <= SQ_W'(ax_r[TOL_W-1:0]) * SQ_W'(ax_r[TOL_W-1:0]);
      sqy_r <= SQ_W'(ay_r[TOL_W-1:0]) * SQ_W'(ay_r[TOL_W-1:0]);
      ltx_r <= ax_r < MAG_W'(dist_tol_r);
      lty_r <= ay_r < MAG_W'(dist_tol_r);
      c2_r  <= c1_r;
    end
    if (stage_en[ST_NEAR]) begin
      c3_r <= c3_nxt;
    end
    if (stage_en[ST_BEAR]) begin
      bear_r      <= bear_nxt;
      hd_bear_r   <= cout.hd;
      near_bear_r <= cout.near;
    end
    if (stage_en[ST_ERR]) begin
      err_raw_r  <= ERRRAW_W'(bear_r) - ERRRAW_W'(hd_bear_r);
      near_err_r <= near_bear_r;
    end
    if (stage_en[ST_WRAP]) begin
      err_r       <= err_nxt;
      near_wrap_r <= near_err_r;
    end
    if (stage_en[ST_MUL]) begin
      prod_r     <= prod_nxt;
      lin_ok_r   <= abs_err <= ERR_W'(head_tol_r);
      near_mul_r <= near_wrap_r;
    end
    if (stage_en[ST_OUT]) begin
      at_goal_r      <= near_mul_r;
      linear_speed_r <= (!near_mul_r && lin_ok_r) ? max_speed_r : '0;
      turn_rate_r    <= near_mul_r ? '0 : rate;
    end
  end

  ggvc_cordic u_cordic (
    .clk     (clk),
    .step_en (stage_en[ST_CORDIC +: CORDIC_N]),
    .cin     (c3_r),
    .cout    (cout)
  );

  assign out_chan.valid        = v_r[ST_OUT];
  assign out_chan.linear_speed = linear_speed_r;
  assign out_chan.turn_rate    = turn_rate_r;
  assign out_chan.at_goal      = at_goal_r;

`ifndef SYNTH
  a_goal_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.at_goal |->
      out_chan.linear_speed == '0 && out_chan.turn_rate == '0)
    else $error("At-goal command is not zero.");

  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_WRAP] |-> (ERRRAW_W'(err_r) > -ANG_PI) && (ERRRAW_W'(err_r) <= ANG_PI))
    else $error("Wrapped heading error is outside the half-open pi interval.");

  a_rate_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (turn_rate_r[RATE_W-1:26] == '0) || (turn_rate_r[RATE_W-1:26] == '1))
    else $error("Turn rate exceeds the bound set by the wrapped error and gain.");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_chan.ready |-> !in_chan.ready)
    else $error("Input transfer offered while every stage is occupied and stalled.");
`endif

endmodule

@@ rtl/core/ggvc_cordic.sv @@
// Pipelined CORDIC vectoring stages, one micro-rotation per register stage.
module ggvc_cordic (
  input  logic                           clk,
  input  logic [ggvc_pkg::CORDIC_N-1:0]  step_en,
  input  ggvc_pkg::cordic_t              cin,
  output ggvc_pkg::cordic_t              cout
);
  import ggvc_pkg::*;

  cordic_t stage_r [CORDIC_N];

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_step
    cordic_t              prev;
    cordic_t              step_nxt;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [ZW-1:0] pz;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] ang;

    if (i == 0) begin : g_first
      assign prev = cin;
    end else begin : g_next
      assign prev = stage_r[i-1];
    end

    assign px  = prev.x;
    assign py  = prev.y;
    assign pz  = prev.z;
    assign xs  = px >>> i;
    assign ys  = py >>> i;
    assign ang = ZW'(ATAN_Q30[i]);

    always_comb begin
      step_nxt = prev;
      if (py > 0) begin
        step_nxt.x = px + ys;
        step_nxt.y = py - xs;
        step_nxt.z = pz + ang;
      end else begin
        step_nxt.x = px - ys;
        step_nxt.y = py + xs;
        step_nxt.z = pz - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (step_en[i]) begin
        stage_r[i] <= step_nxt;
      end
    end
  end

  assign cout = stage_r[CORDIC_N-1];

endmodule
